// ----- sv/shash_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package shash_pkg;

    // input and result beats
    typedef struct packed {
        logic       mode;
        logic [7:0] message_byte;
    } t_in;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out;

    // beat kinds
    localparam logic MODE_DATA   = 1'b0;
    localparam logic MODE_FINISH = 1'b1;

    // padding and length bookkeeping
    localparam logic [7:0]  PAD_BYTE       = 8'h80;
    localparam logic [63:0] BLOCK_BITS     = 64'd512;
    localparam logic [5:0]  LEN_FIELD_BYTE = 6'd56;

    // memory geometry
    localparam int BLK_WORDS  = 16;
    localparam int HASH_WORDS = 8;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_LOAD,
        S_ROUND,
        S_UPD,
        S_ORD,
        S_OWR
    } t_state;

    // controls from the sequencer to the round datapath
    typedef struct packed {
        logic       shift;
        logic       round;
        logic       w_from_mem;
        logic [5:0] kidx;
    } t_core_ctl;

    localparam logic [31:0] H_INIT [HASH_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

endpackage

`default_nettype wire

// ----- sv/shash_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module shash_ram #(
    parameter int  DEPTH = 16,
    parameter int  WIDTH = 32,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port, holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- sv/shash_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

module shash_core (
    input  wire logic                 i_clk,
    input  wire shash_pkg::t_core_ctl i_ctl,
    input  wire logic [31:0]          i_hdata,
    input  wire logic [31:0]          i_bdata,
    output logic      [31:0]          o_a
);

    import shash_pkg::*;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // working variables a..h and the sixteen word schedule window
    logic [31:0] r_v [8];
    logic [31:0] r_w [16];

    logic [31:0] wt;
    logic [31:0] s0;
    logic [31:0] s1;
    logic [31:0] bs0;
    logic [31:0] bs1;
    logic [31:0] ch;
    logic [31:0] maj;
    logic [31:0] t1;
    logic [31:0] t2;

    // schedule word: straight from the block for the first sixteen rounds
    always_comb begin
        s0  = rotr(r_w[1], 7) ^ rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        s1  = rotr(r_w[14], 17) ^ rotr(r_w[14], 19) ^ (r_w[14] >> 10);
        wt  = i_ctl.w_from_mem ? i_bdata : (s1 + r_w[9] + s0 + r_w[0]);
        bs1 = rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25);
        bs0 = rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22);
        ch  = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        maj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t1  = r_v[7] + bs1 + ch + ROUND_K[i_ctl.kidx] + wt;
        t2  = bs0 + maj;
    end

    // load / drain shift, or one round
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            for (int i = 0; i < 7; i++) begin
                r_v[i] <= r_v[i+1];
            end
            r_v[7] <= i_hdata;
        end else if (i_ctl.round) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= wt;
        end
    end

    assign o_a = r_v[0];

endmodule

`default_nettype wire

// ----- sv/sha256_stream_hasher.sv -----
`timescale 1ns / 1ps
`default_nettype none

// SHA-256 over a byte stream.
// Input channel (i_valid / o_stall, payload i_data): a data beat carries one
// message byte, a finish beat closes the message. Output channel (o_valid /
// i_stall, payload o_data): eight digest words per finish, word 0 first,
// last_word set on word 7.
// A data beat is taken whenever the hasher is idle. The 64th byte of a block
// starts a compression: the hash words are loaded from the hash memory, 64
// rounds run at one per cycle, then the hash words are added and written
// back, with o_stall high throughout; no new byte is taken meanwhile.
// A finish beat first writes the padding into the block memory, one word per
// cycle from the current word to word 15, then compresses; with 56 or more
// bytes held a second pad pass over all sixteen words and a second
// compression follow. The digest is then read out of the hash memory word
// by word; while the receiver stalls the output register holds and the
// read-out waits. After the eighth word is in the output register new beats
// are taken again, and the next message starts from the initial hash values.
// Reset (i_rst_n low, synchronous) empties the block, clears the bit count,
// marks all hash words as initial values and drops o_valid.

module sha256_stream_hasher (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_stall,
    input  wire shash_pkg::t_in  i_data,
    output logic                 o_valid,
    input  wire logic            i_stall,
    output shash_pkg::t_out      o_data
);

    import shash_pkg::*;

    t_state      r_state;
    t_state      n_state;
    logic [5:0]  r_cnt;
    logic [5:0]  n_cnt;
    logic [5:0]  r_fill;
    logic [5:0]  n_fill;
    logic [63:0] r_bitlen;
    logic [63:0] n_bitlen;
    logic [23:0] r_wbuf;
    logic [23:0] n_wbuf;
    logic [3:0]  r_widx;
    logic [3:0]  n_widx;
    logic [31:0] r_padw;
    logic [31:0] n_padw;
    logic        r_first;
    logic        n_first;
    logic        r_lenblk;
    logic        n_lenblk;
    logic        r_fin;
    logic        n_fin;
    logic [7:0]  r_hval;
    logic [7:0]  n_hval;
    logic [2:0]  r_hra;
    logic        r_hrv;
    logic        r_ovalid;
    logic        n_ovalid;
    t_out        r_out;
    t_out        n_out;

    // memory ports
    logic        b_we;
    logic [3:0]  b_waddr;
    logic [31:0] b_wdata;
    logic        b_re;
    logic [3:0]  b_raddr;
    logic [31:0] b_q;
    logic        h_we;
    logic [2:0]  h_waddr;
    logic [31:0] h_wdata;
    logic        h_re;
    logic [2:0]  h_raddr;
    logic [31:0] h_q;
    logic [31:0] hdata;
    logic [31:0] core_a;
    t_core_ctl   ctl;

    // message block, sixteen big-endian words
    shash_ram #(.DEPTH(BLK_WORDS), .WIDTH(32)) u_blk (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (b_waddr),
        .i_wdata (b_wdata),
        .i_re    (b_re),
        .i_raddr (b_raddr),
        .o_rdata (b_q)
    );

    // chaining hash words
    shash_ram #(.DEPTH(HASH_WORDS), .WIDTH(32)) u_hash (
        .i_clk   (i_clk),
        .i_we    (h_we),
        .i_waddr (h_waddr),
        .i_wdata (h_wdata),
        .i_re    (h_re),
        .i_raddr (h_raddr),
        .o_rdata (h_q)
    );

    shash_core u_core (
        .i_clk   (i_clk),
        .i_ctl   (ctl),
        .i_hdata (hdata),
        .i_bdata (b_q),
        .o_a     (core_a)
    );

    // a hash word never written since the last message reads as its initial value
    assign hdata   = r_hrv ? h_q : H_INIT[r_hra];
    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ovalid;
    assign o_data  = r_out;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state, memory accesses and datapath controls
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_fill   = r_fill;
        n_bitlen = r_bitlen;
        n_wbuf   = r_wbuf;
        n_widx   = r_widx;
        n_padw   = r_padw;
        n_first  = r_first;
        n_lenblk = r_lenblk;
        n_fin    = r_fin;
        n_hval   = r_hval;
        n_ovalid = r_ovalid && i_stall;
        n_out    = r_out;
        b_we     = 1'b0;
        b_waddr  = r_fill[5:2];
        b_wdata  = {r_wbuf, i_data.message_byte};
        b_re     = 1'b0;
        b_raddr  = '0;
        h_we     = 1'b0;
        h_waddr  = r_hra;
        h_wdata  = hdata + core_a;
        h_re     = 1'b0;
        h_raddr  = r_cnt[2:0];
        ctl      = '0;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_data.mode == MODE_DATA) begin
                        // gather bytes, write a word every fourth byte
                        b_we     = (r_fill[1:0] == 2'b11);
                        n_wbuf   = {r_wbuf[15:0], i_data.message_byte};
                        n_fill   = r_fill + 6'd1;
                        if (r_fill == 6'd63) begin
                            n_state  = S_LOAD;
                            n_cnt    = '0;
                            n_bitlen = r_bitlen + BLOCK_BITS;
                            n_fin    = 1'b0;
                        end
                    end else begin
                        // close the message: length, pad word, pad pass
                        n_bitlen = r_bitlen + {55'd0, r_fill, 3'd0};
                        n_fill   = '0;
                        n_widx   = r_fill[5:2];
                        n_first  = 1'b1;
                        n_lenblk = (r_fill < LEN_FIELD_BYTE);
                        n_fin    = 1'b1;
                        n_state  = S_PAD;
                        case (r_fill[1:0])
                            2'd0:    n_padw = {PAD_BYTE, 24'd0};
                            2'd1:    n_padw = {r_wbuf[7:0], PAD_BYTE, 16'd0};
                            2'd2:    n_padw = {r_wbuf[15:0], PAD_BYTE, 8'd0};
                            default: n_padw = {r_wbuf, PAD_BYTE};
                        endcase
                    end
                end
            end
            S_PAD: begin
                // one padding word per cycle up to the end of the block
                b_we    = 1'b1;
                b_waddr = r_widx;
                if (r_first) begin
                    b_wdata = r_padw;
                end else if (r_lenblk && (r_widx == 4'd14)) begin
                    b_wdata = r_bitlen[63:32];
                end else if (r_lenblk && (r_widx == 4'd15)) begin
                    b_wdata = r_bitlen[31:0];
                end else begin
                    b_wdata = '0;
                end
                n_first = 1'b0;
                if (r_widx == 4'd15) begin
                    n_state = S_LOAD;
                    n_cnt   = '0;
                end else begin
                    n_widx = r_widx + 4'd1;
                end
            end
            S_LOAD: begin
                // read the hash words into the working variables
                h_re      = !r_cnt[3];
                ctl.shift = (r_cnt != 6'd0);
                if (r_cnt[3]) begin
                    b_re    = 1'b1;
                    b_raddr = '0;
                    n_state = S_ROUND;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 6'd1;
                end
            end
            S_ROUND: begin
                // one round a cycle, block words fetched a cycle ahead
                ctl.round      = 1'b1;
                ctl.w_from_mem = (r_cnt[5:4] == 2'b00);
                ctl.kidx       = r_cnt;
                b_re           = (r_cnt < 6'd15);
                b_raddr        = r_cnt[3:0] + 4'd1;
                if (r_cnt == 6'd63) begin
                    n_state = S_UPD;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 6'd1;
                end
            end
            S_UPD: begin
                // read-add-write of each hash word
                h_re = !r_cnt[3];
                if (r_cnt != 6'd0) begin
                    h_we          = 1'b1;
                    ctl.shift     = 1'b1;
                    n_hval[r_hra] = 1'b1;
                end
                if (r_cnt[3]) begin
                    n_cnt = '0;
                    if (!r_fin) begin
                        n_state = S_IDLE;
                    end else if (!r_lenblk) begin
                        n_state  = S_PAD;
                        n_widx   = '0;
                        n_lenblk = 1'b1;
                    end else begin
                        n_state = S_ORD;
                    end
                end else begin
                    n_cnt = r_cnt + 6'd1;
                end
            end
            S_ORD: begin
                h_re    = 1'b1;
                n_state = S_OWR;
            end
            S_OWR: begin
                // hand a digest word to the output register once it is free
                if (!r_ovalid || !i_stall) begin
                    n_ovalid          = 1'b1;
                    n_out.digest_word = hdata;
                    n_out.word_index  = r_cnt[2:0];
                    n_out.last_word   = (r_cnt[2:0] == 3'd7);
                    if (r_cnt[2:0] == 3'd7) begin
                        n_state  = S_IDLE;
                        n_cnt    = '0;
                        n_hval   = '0;
                        n_bitlen = '0;
                    end else begin
                        n_state = S_ORD;
                        n_cnt   = r_cnt + 6'd1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_fill   <= '0;
            r_bitlen <= '0;
            r_widx   <= '0;
            r_first  <= 1'b0;
            r_lenblk <= 1'b0;
            r_fin    <= 1'b0;
            r_hval   <= '0;
            r_hrv    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_cnt    <= n_cnt;
            r_fill   <= n_fill;
            r_bitlen <= n_bitlen;
            r_widx   <= n_widx;
            r_first  <= n_first;
            r_lenblk <= n_lenblk;
            r_fin    <= n_fin;
            r_hval   <= n_hval;
            r_ovalid <= n_ovalid;
            if (h_re) begin
                r_hrv <= r_hval[h_raddr];
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_wbuf <= n_wbuf;
        r_padw <= n_padw;
        r_out  <= n_out;
        if (h_re) begin
            r_hra <= h_raddr;
        end
    end

endmodule

`default_nettype wire

// ----- sv/shash_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module shash_checker (
    input wire logic            i_clk,
    input wire logic            i_rst_n,
    input wire logic            i_valid,
    input wire logic            o_stall,
    input wire shash_pkg::t_in  i_data,
    input wire logic            o_valid,
    input wire logic            i_stall,
    input wire shash_pkg::t_out o_data
);

    import shash_pkg::*;

    // output register empty straight after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // a stalled digest beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("stalled digest beat changed");

    // last_word marks word seven and only that
    a_last_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.last_word == (o_data.word_index == 3'd7)))
        else $error("last_word does not match word_index");

    // digest words come out in order
    a_word_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_data.last_word |=>
            !o_valid || (o_data.word_index == $past(o_data.word_index) + 3'd1))
        else $error("digest word out of order");

    // a finish beat holds off further input while it is worked on
    a_finish_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && (i_data.mode == MODE_FINISH) |=> o_stall)
        else $error("input taken during finish");

endmodule

bind sha256_stream_hasher shash_checker u_shash_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .i_data  (i_data),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    import shash_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 300;
    localparam int RAND_ITEMS   = 150;
    localparam int IDLE_PCT     = 34;

    // well-known digests of the empty message and of "abc"
    localparam logic [255:0] DIG_EMPTY =
        256'he3b0c44298fc1c149afbf4c8996fb92427ae41e4649b934ca495991b7852b855;
    localparam logic [255:0] DIG_ABC =
        256'hba7816bf8f01cfea414140de5dae2223b00361a396177a9cb410ff61f20015ad;

    // one stimulus row: the beat, plus a typed-in digest where one is known
    typedef struct packed {
        logic         known;
        logic [255:0] digest;
        t_in          beat;
    } t_row;

    localparam int DIR_N = 17;
    localparam t_row DIR_TAB [DIR_N] = '{
        {1'b1, DIG_EMPTY, MODE_FINISH, 8'h00},
        {1'b1, DIG_EMPTY, MODE_FINISH, 8'hff},
        {1'b0, 256'd0,    MODE_DATA,   8'h61},
        {1'b0, 256'd0,    MODE_DATA,   8'h62},
        {1'b0, 256'd0,    MODE_DATA,   8'h63},
        {1'b1, DIG_ABC,   MODE_FINISH, 8'h5a},
        {1'b0, 256'd0,    MODE_DATA,   8'h00},
        {1'b0, 256'd0,    MODE_FINISH, 8'h00},
        {1'b0, 256'd0,    MODE_DATA,   8'hff},
        {1'b0, 256'd0,    MODE_FINISH, 8'hff},
        {1'b0, 256'd0,    MODE_DATA,   8'h61},
        {1'b0, 256'd0,    MODE_DATA,   8'h62},
        {1'b0, 256'd0,    MODE_DATA,   8'h63},
        {1'b1, DIG_ABC,   MODE_FINISH, 8'ha5},
        {1'b0, 256'd0,    MODE_DATA,   8'h80},
        {1'b0, 256'd0,    MODE_DATA,   8'h7f},
        {1'b0, 256'd0,    MODE_FINISH, 8'hff}
    };

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    t_in  i_data  = '0;
    logic i_stall = 1'b0;
    logic o_stall;
    logic o_valid;
    t_out o_data;

    sha256_stream_hasher dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    // stimulus and bookkeeping
    t_row stim_q [$];
    t_out digest_q [$];
    int   send_idx   = 0;
    int   calm_lo    = 0;
    int   calm_hi    = 0;
    int   words_seen = 0;
    int   msg_cnt    = 0;
    int   err_cnt    = 0;
    int   cycle_cnt  = 0;
    int   hold_left  = 0;
    bit   held       = 1'b0;

    // predicted hash state
    logic [31:0] hv [8];
    logic [7:0]  blk [64];
    logic [5:0]  fill;
    logic [63:0] bits;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // one 64-round compression of the block into the hash words
    task automatic sha_compress();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] s0, s1, t1, t2, e, a;
        for (int i = 0; i < 16; i++)
            w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
        for (int i = 16; i < 64; i++) begin
            s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = s1 + w[i-7] + s0 + w[i-16];
        end
        for (int i = 0; i < 8; i++)
            v[i] = hv[i];
        for (int i = 0; i < 64; i++) begin
            e  = v[4];
            a  = v[0];
            t1 = v[7] + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) +
                 ((e & v[5]) ^ (~e & v[6])) + ROUND_K[i] + w[i];
            t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) +
                 ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            hv[i] = hv[i] + v[i];
    endtask

    // absorb one accepted beat; a finish queues its eight digest words
    task automatic sha_absorb(input t_row r);
        logic [5:0] pos;
        t_out       w;
        if (r.beat.mode == MODE_DATA) begin
            blk[fill] = r.beat.message_byte;
            fill = fill + 6'd1;
            if (fill == 6'd0) begin
                sha_compress();
                bits = bits + BLOCK_BITS;
            end
        end else begin
            pos  = fill;
            bits = bits + 64'(pos) * 64'd8;
            blk[pos] = PAD_BYTE;
            for (int i = int'(pos) + 1; i < 64; i++)
                blk[i] = 8'h00;
            // long tail: the pad byte block goes out on its own
            if (pos >= LEN_FIELD_BYTE) begin
                sha_compress();
                for (int i = 0; i < 56; i++)
                    blk[i] = 8'h00;
            end
            for (int k = 0; k < 8; k++)
                blk[56+k] = bits[63-8*k -: 8];
            sha_compress();
            for (int k = 0; k < 8; k++) begin
                w.digest_word = r.known ? r.digest[255-32*k -: 32] : hv[k];
                w.word_index  = 3'(k);
                w.last_word   = (k == 7);
                digest_q.push_back(w);
            end
            for (int i = 0; i < 8; i++)
                hv[i] = H_INIT[i];
            fill    = 6'd0;
            bits    = 64'd0;
            msg_cnt = msg_cnt + 1;
        end
    endtask

    // a message of random bytes closed by a finish beat
    task automatic queue_message(input int len);
        t_row r;
        r.known  = 1'b0;
        r.digest = '0;
        for (int i = 0; i < len; i++) begin
            r.beat.mode         = MODE_DATA;
            r.beat.message_byte = 8'($urandom_range(0, 255));
            stim_q.push_back(r);
        end
        r.beat.mode         = MODE_FINISH;
        r.beat.message_byte = 8'($urandom_range(0, 255));
        stim_q.push_back(r);
    endtask

    // sender: offers rows in order, idles at random outside the calm stretch
    always @(posedge i_clk) begin
        logic nxt_valid;
        t_in  nxt_data;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            nxt_valid = i_valid;
            nxt_data  = i_data;
            if (i_valid && !o_stall) begin
                sha_absorb(stim_q[send_idx]);
                send_idx  = send_idx + 1;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid && send_idx < stim_q.size()) begin
                if ((send_idx >= calm_lo && send_idx < calm_hi) ||
                    $urandom_range(0, 99) >= IDLE_PCT) begin
                    nxt_valid = 1'b1;
                    nxt_data  = stim_q[send_idx].beat;
                end
            end
            i_valid <= nxt_valid;
            i_data  <= nxt_data;
        end
    end

    // receiver: checks each digest beat, stalls at random, one long hold-off, no stalls over a middle stretch
    always @(posedge i_clk) begin
        t_out want;
        logic nxt_stall;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (digest_q.size() == 0) begin
                    $error("unexpected digest beat: word %h index %0d",
                           o_data.digest_word, o_data.word_index);
                    err_cnt = err_cnt + 1;
                end else begin
                    want = digest_q.pop_front();
                    if (o_data.digest_word !== want.digest_word) begin
                        $error("digest_word: expected %h, actual %h",
                               want.digest_word, o_data.digest_word);
                        err_cnt = err_cnt + 1;
                    end
                    if (o_data.word_index !== want.word_index) begin
                        $error("word_index: expected %0d, actual %0d",
                               want.word_index, o_data.word_index);
                        err_cnt = err_cnt + 1;
                    end
                    if (o_data.last_word !== want.last_word) begin
                        $error("last_word: expected %0d, actual %0d",
                               want.last_word, o_data.last_word);
                        err_cnt = err_cnt + 1;
                    end
                end
                words_seen = words_seen + 1;
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                nxt_stall = 1'b1;
            end else if (!held && words_seen >= 8 && o_valid) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
                nxt_stall = 1'b1;
            end else if (words_seen >= 24 && words_seen < 56) begin
                nxt_stall = 1'b0;
            end else begin
                nxt_stall = ($urandom_range(0, 99) < IDLE_PCT);
            end
            i_stall <= nxt_stall;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt = cycle_cnt + 1;
        if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        int rand_start;
        int len;
        // predictor starts from the reset state
        for (int i = 0; i < 8; i++)
            hv[i] = H_INIT[i];
        for (int i = 0; i < 64; i++)
            blk[i] = 8'h00;
        fill = 6'd0;
        bits = 64'd0;

        // directed rows
        for (int i = 0; i < DIR_N; i++)
            stim_q.push_back(DIR_TAB[i]);

        // random part: a full block with no idling, a long tail, then short messages
        rand_start = stim_q.size();
        calm_lo    = stim_q.size();
        queue_message(64);
        calm_hi    = stim_q.size();
        queue_message($urandom_range(56, 63));
        while (stim_q.size() - rand_start < RAND_ITEMS) begin
            len = ($urandom_range(0, 99) < 10) ? 0 : $urandom_range(1, 14);
            queue_message(len);
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // wait for every beat to go in and every digest word to come out
        forever begin
            @(negedge i_clk);
            if (send_idx == stim_q.size() && digest_q.size() == 0)
                break;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d beats over %0d messages, checked %0d digest words",
                 send_idx, msg_cnt, words_seen);
        $display("includes empty, full-block and long-tail messages and a %0d-cycle hold-off",
                 HOLD_CYCLES);
        if (err_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
